@@ sv/ibt_pkg.sv @@
// ibt_pkg: shared types and constants for the indexed bound tracker
// holds command and state codes, config register map and the config control struct
// no dependencies
package ibt_pkg;

    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int CMD_BITS = 2;
    localparam int IDX_BITS = 6;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    // register index within the config space
    localparam logic [REG_IDX_BITS-1:0] REG_MODE = '0;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_TEST    = 2'd2,
        CMD_COMBINE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_DONE
    } state_t;

    // config side to core: current mode plus a reinit strobe with the new mode
    typedef struct packed {
        logic min_is_best;
        logic reinit;
        logic reinit_mode;
    } cfg_ctl_t;

endpackage

@@ sv/ibt_bound_ram.sv @@
// ibt_bound_ram: bound value table, one write port and one registered read port
// depends on ibt_pkg for parameter defaults
module ibt_bound_ram #(
    parameter int DEPTH = ibt_pkg::DEF_ENTRIES,
    parameter int WIDTH = ibt_pkg::DEF_VALUE_BITS
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] bound_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bound_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= bound_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ibt_cfg.sv @@
// ibt_cfg: apb register slice holding the mode register
// depends on ibt_pkg for the register map and the control struct
module ibt_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ibt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [ibt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [ibt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output ibt_pkg::cfg_ctl_t                  ctl
);

    import ibt_pkg::*;

    logic                    min_is_best_reg;
    logic                    min_is_best_next;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == REG_MODE);

    always_comb
    begin
        min_is_best_next = wr_hit ? pwdata[0] : min_is_best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_is_best_reg <= 1'b1;
        end
        else
        begin
            min_is_best_reg <= min_is_best_next;
        end
    end

    assign prdata = (reg_idx == REG_MODE) ? APB_DATA_BITS'(min_is_best_reg) : '0;

    assign ctl.min_is_best = min_is_best_reg;
    assign ctl.reinit      = wr_hit;
    assign ctl.reinit_mode = pwdata[0];

endmodule

@@ sv/ibt_core.sv @@
// ibt_core: command sequencer, valid bits, best/worst trackers and result register
// depends on ibt_pkg; drives the table memory ibt_bound_ram
module ibt_core #(
    parameter int ENTRIES    = ibt_pkg::DEF_ENTRIES,
    parameter int VALUE_BITS = ibt_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ibt_pkg::cfg_ctl_t                   cfg,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ibt_pkg::CMD_BITS-1:0]        command,
    input  logic [ibt_pkg::IDX_BITS-1:0]        entry_index,
    input  logic signed [VALUE_BITS-1:0]        bound_value,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [VALUE_BITS-1:0]        best_value,
    output logic signed [VALUE_BITS-1:0]        worst_value,
    output logic [ibt_pkg::IDX_BITS-1:0]        best_entry,
    output logic                                best_found,
    output logic                                is_better,
    output logic signed [VALUE_BITS-1:0]        combined_value,

    output logic                                mem_wr_en,
    output logic [$clog2(ENTRIES)-1:0]          mem_wr_addr,
    output logic [VALUE_BITS-1:0]               mem_wr_data,
    output logic [$clog2(ENTRIES)-1:0]          mem_rd_addr,
    input  logic [VALUE_BITS-1:0]               mem_rd_data
);

    import ibt_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW:0]   SCAN_END  = (AW+1)'(ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
    localparam logic signed [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // strict improvement / strict degradation under the current mode
    function automatic logic beats(input logic mib,
                                   input logic signed [VALUE_BITS-1:0] a,
                                   input logic signed [VALUE_BITS-1:0] b);
        beats = mib ? (a < b) : (a > b);
    endfunction

    function automatic logic loses(input logic mib,
                                   input logic signed [VALUE_BITS-1:0] a,
                                   input logic signed [VALUE_BITS-1:0] b);
        loses = mib ? (a > b) : (a < b);
    endfunction

    state_t                        state_reg, state_next;
    cmd_t                          cmd_reg, cmd_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic                          range_reg, range_next;
    logic signed [VALUE_BITS-1:0]  val_reg, val_next;

    logic [ENTRIES-1:0]            valid_reg, valid_next;
    logic signed [VALUE_BITS-1:0]  best_reg, best_next;
    logic signed [VALUE_BITS-1:0]  worst_reg, worst_next;
    logic [AW-1:0]                 slot_reg, slot_next;
    logic                          slot_ok_reg, slot_ok_next;
    logic                          better_reg, better_next;
    logic signed [VALUE_BITS-1:0]  comb_reg, comb_next;

    logic [AW:0]                   scan_cnt_reg, scan_cnt_next;
    logic                          scan_pipe_reg, scan_pipe_next;
    logic [AW-1:0]                 scan_addr_reg, scan_addr_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_BITS-1:0]  out_best_reg, out_best_next;
    logic signed [VALUE_BITS-1:0]  out_worst_reg, out_worst_next;
    logic [IDX_BITS-1:0]           out_entry_reg, out_entry_next;
    logic                          out_found_reg, out_found_next;
    logic                          out_better_reg, out_better_next;
    logic signed [VALUE_BITS-1:0]  out_comb_reg, out_comb_next;

    logic                          mib;
    logic                          in_range;
    logic signed [VALUE_BITS-1:0]  old_val;
    logic                          old_ok;
    logic                          hit;
    logic                          scan_start;
    logic                          out_load;
    logic signed [VALUE_BITS-1:0]  best_empty;
    logic signed [VALUE_BITS-1:0]  worst_empty;

    assign mib         = cfg.min_is_best;
    assign best_empty  = mib ? V_MAX : V_MIN;
    assign worst_empty = mib ? V_MIN : V_MAX;
    assign in_range    = (int'(entry_index) < ENTRIES);
    assign old_val     = mem_rd_data;
    assign old_ok      = range_reg && valid_reg[idx_reg];
    assign hit         = old_ok && ((old_val == best_reg) || (old_val == worst_reg));
    assign in_stall    = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        range_next      = range_reg;
        val_next        = val_reg;
        valid_next      = valid_reg;
        best_next       = best_reg;
        worst_next      = worst_reg;
        slot_next       = slot_reg;
        slot_ok_next    = slot_ok_reg;
        better_next     = better_reg;
        comb_next       = comb_reg;
        scan_cnt_next   = scan_cnt_reg;
        scan_pipe_next  = scan_pipe_reg;
        scan_addr_next  = scan_addr_reg;
        out_best_next   = out_best_reg;
        out_worst_next  = out_worst_reg;
        out_entry_next  = out_entry_reg;
        out_found_next  = out_found_reg;
        out_better_next = out_better_reg;
        out_comb_next   = out_comb_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = val_reg;
        mem_rd_addr     = AW'(entry_index);
        scan_start      = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // table read for the addressed entry goes out with the transfer
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(command);
                    idx_next   = AW'(entry_index);
                    range_next = in_range;
                    val_next   = bound_value;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                better_next = 1'b0;
                comb_next   = '0;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (range_reg)
                        begin
                            mem_wr_en           = 1'b1;
                            valid_next[idx_reg] = 1'b1;
                            if (hit)
                            begin
                                scan_start = 1'b1;
                            end
                            else
                            begin
                                if (beats(mib, val_reg, best_reg))
                                begin
                                    best_next    = val_reg;
                                    slot_next    = idx_reg;
                                    slot_ok_next = 1'b1;
                                end
                                if (loses(mib, val_reg, worst_reg))
                                begin
                                    worst_next = val_reg;
                                end
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (old_ok)
                        begin
                            valid_next[idx_reg] = 1'b0;
                            scan_start          = hit;
                        end
                    end
                    CMD_TEST:
                    begin
                        better_next = !(old_ok &&
                                        (mib ? (val_reg <= old_val) : (val_reg >= old_val)));
                    end
                    CMD_COMBINE:
                    begin
                        comb_next = beats(mib, val_reg, best_reg) ? val_reg : best_reg;
                    end
                    default:
                    begin
                        comb_next = '0;
                    end
                endcase
                if (scan_start)
                begin
                    best_next      = best_empty;
                    worst_next     = worst_empty;
                    slot_next      = '0;
                    slot_ok_next   = 1'b0;
                    scan_cnt_next  = '0;
                    scan_pipe_next = 1'b0;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                // issue one read a cycle, fold in the entry read the cycle before
                mem_rd_addr = scan_cnt_reg[AW-1:0];
                if (scan_cnt_reg != SCAN_END)
                begin
                    scan_cnt_next  = scan_cnt_reg + (AW+1)'(1);
                    scan_pipe_next = 1'b1;
                    scan_addr_next = scan_cnt_reg[AW-1:0];
                end
                else
                begin
                    scan_pipe_next = 1'b0;
                end
                if (scan_pipe_reg)
                begin
                    if (valid_reg[scan_addr_reg])
                    begin
                        if (beats(mib, old_val, best_reg))
                        begin
                            best_next    = old_val;
                            slot_next    = scan_addr_reg;
                            slot_ok_next = 1'b1;
                        end
                        if (loses(mib, old_val, worst_reg))
                        begin
                            worst_next = old_val;
                        end
                    end
                    if (scan_addr_reg == LAST_ADDR)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load        = 1'b1;
                    out_best_next   = best_reg;
                    out_worst_next  = worst_reg;
                    out_entry_next  = slot_ok_reg ? IDX_BITS'(slot_reg) : '0;
                    out_found_next  = slot_ok_reg;
                    out_better_next = better_reg;
                    out_comb_next   = comb_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end

        // mode write empties the table and resets the trackers for the new mode
        if (cfg.reinit)
        begin
            valid_next   = '0;
            best_next    = cfg.reinit_mode ? V_MAX : V_MIN;
            worst_next   = cfg.reinit_mode ? V_MIN : V_MAX;
            slot_next    = '0;
            slot_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            best_reg      <= V_MAX;
            worst_reg     <= V_MIN;
            slot_reg      <= '0;
            slot_ok_reg   <= 1'b0;
            scan_cnt_reg  <= '0;
            scan_pipe_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            best_reg      <= best_next;
            worst_reg     <= worst_next;
            slot_reg      <= slot_next;
            slot_ok_reg   <= slot_ok_next;
            scan_cnt_reg  <= scan_cnt_next;
            scan_pipe_reg <= scan_pipe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        range_reg      <= range_next;
        val_reg        <= val_next;
        better_reg     <= better_next;
        comb_reg       <= comb_next;
        scan_addr_reg  <= scan_addr_next;
        out_best_reg   <= out_best_next;
        out_worst_reg  <= out_worst_next;
        out_entry_reg  <= out_entry_next;
        out_found_reg  <= out_found_next;
        out_better_reg <= out_better_next;
        out_comb_reg   <= out_comb_next;
    end

    assign out_valid      = out_valid_reg;
    assign best_value     = out_best_reg;
    assign worst_value    = out_worst_reg;
    assign best_entry     = out_entry_reg;
    assign best_found     = out_found_reg;
    assign is_better      = out_better_reg;
    assign combined_value = out_comb_reg;

`ifndef SYNTH
    a_slot_clear_without_best: assert property (@(posedge clk) disable iff (!rst_n)
        !slot_ok_reg |-> (slot_reg == '0))
        else $error("best slot nonzero while no entry holds the best");

    a_best_slot_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && slot_ok_reg) |-> valid_reg[slot_reg])
        else $error("best slot points at an empty entry");

    a_empty_table_sentinels: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && valid_reg == '0) |->
            (best_reg == best_empty && worst_reg == worst_empty && !slot_ok_reg))
        else $error("empty table without sentinel best and worst");
`endif

endmodule

@@ sv/indexed_bound_best_worst_tracker.sv @@
// indexed_bound_best_worst_tracker: top level of the indexed bound tracker
// depends on ibt_pkg, ibt_cfg, ibt_core and ibt_bound_ram
//
//   channel   direction   handshake             payload
//   in        sink        in_valid / in_stall   command, entry_index, bound_value
//   out       source      out_valid / out_stall best_value, worst_value, best_entry,
//                                               best_found, is_better, combined_value
//   config    apb slave   psel/penable/pready   min_is_best at byte address 0
//
// one item at a time: a transfer on in goes through table read, evaluate and load into the output
// register, with a rescan of the table between evaluate and load when it removes or overwrites
// the entry holding the best or worst value, since the trackers are then rebuilt by reading
// every entry through the single table read port
// the output register lets the next input transfer start while a result waits on out_stall
// reset clears all valid bits and sets best/worst to the sentinel extremes for min-is-best
// a mode write clears the table the same way and takes effect at once
module indexed_bound_best_worst_tracker #(
    parameter int ENTRIES    = ibt_pkg::DEF_ENTRIES,
    parameter int VALUE_BITS = ibt_pkg::DEF_VALUE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ibt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [ibt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [ibt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ibt_pkg::CMD_BITS-1:0]       command,
    input  logic [ibt_pkg::IDX_BITS-1:0]       entry_index,
    input  logic signed [VALUE_BITS-1:0]       bound_value,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [VALUE_BITS-1:0]       best_value,
    output logic signed [VALUE_BITS-1:0]       worst_value,
    output logic [ibt_pkg::IDX_BITS-1:0]       best_entry,
    output logic                               best_found,
    output logic                               is_better,
    output logic signed [VALUE_BITS-1:0]       combined_value
);

    import ibt_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    // mode register and reinit strobe toward the core
    cfg_ctl_t               cfg_ctl;

    // table memory port
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [VALUE_BITS-1:0]  mem_wr_data;
    logic [AW-1:0]          mem_rd_addr;
    logic [VALUE_BITS-1:0]  mem_rd_data;

    ibt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctl     (cfg_ctl)
    );

    // sequencer: reads the addressed entry, updates trackers, rescans when needed
    ibt_core #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ctl),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .entry_index    (entry_index),
        .bound_value    (bound_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .best_value     (best_value),
        .worst_value    (worst_value),
        .best_entry     (best_entry),
        .best_found     (best_found),
        .is_better      (is_better),
        .combined_value (combined_value),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

    // bound values; entries are only used while their valid bit is set
    ibt_bound_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

@@ dv/tb.sv @@
// tb: self-checking testbench for indexed_bound_best_worst_tracker
// runs a directed table of commands, then random command streams under several modes,
// with an in-file tracker model; depends on ibt_pkg and the rtl under sv/
module tb;

    import ibt_pkg::*;

    localparam int ENTRIES        = DEF_ENTRIES;
    localparam int VB             = DEF_VALUE_BITS;
    localparam int PHASES         = 5;
    localparam int RAND_PER_PHASE = 230;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = ENTRIES + 20;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DIR_LEN        = 25;

    typedef logic signed [VB-1:0] bound_t;
    typedef logic [IDX_BITS-1:0]  slot_t;

    // sentinel extremes, used as infinity when no entry is valid
    localparam bound_t POS_INF = bound_t'({1'b0, {(VB-1){1'b1}}});
    localparam bound_t NEG_INF = ~POS_INF;

    localparam logic [APB_ADDR_BITS-1:0] MODE_ADDR = {REG_MODE, 2'b00};

    // one result transfer, field for field
    typedef struct packed {
        bound_t     best_value;
        bound_t     worst_value;
        slot_t      best_entry;
        logic       best_found;
        logic       is_better;
        bound_t     combined_value;
    } tracker_out_t;

    localparam tracker_out_t NO_OUT = '0;

    // one row of the directed table
    // mode_wr: drain and rewrite the mode register before this row
    // typed: the result below is written out by hand, else the tracker model supplies it
    typedef struct packed {
        logic         mode_wr;
        logic         mode_val;
        cmd_t         cmd;
        slot_t        idx;
        bound_t       val;
        logic         typed;
        tracker_out_t want;
    } stim_row_t;

    localparam stim_row_t DIR_ROWS [DIR_LEN] = '{
        // min is best after reset, table empty
        '{1'b0, 1'b0, CMD_TEST,    6'd0,  32'sd0,   1'b1,
          '{POS_INF, NEG_INF, 6'd0, 1'b0, 1'b1, 32'sd0}},
        '{1'b0, 1'b0, CMD_COMBINE, 6'd63, 32'sd5,   1'b1,
          '{POS_INF, NEG_INF, 6'd0, 1'b0, 1'b0, 32'sd5}},
        // remove of an absent entry changes nothing
        '{1'b0, 1'b0, CMD_REMOVE,  6'd10, 32'sd0,   1'b1,
          '{POS_INF, NEG_INF, 6'd0, 1'b0, 1'b0, 32'sd0}},
        // value equal to the infinity sentinel: stored, but no best yet
        '{1'b0, 1'b0, CMD_INSERT,  6'd63, POS_INF,  1'b1,
          '{POS_INF, POS_INF, 6'd0, 1'b0, 1'b0, 32'sd0}},
        '{1'b0, 1'b0, CMD_INSERT,  6'd0,  NEG_INF,  1'b1,
          '{NEG_INF, POS_INF, 6'd0, 1'b1, 1'b0, 32'sd0}},
        '{1'b0, 1'b0, CMD_INSERT,  6'd5,  32'sd100, 1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_INSERT,  6'd6,  -32'sd7,  1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_TEST,    6'd5,  32'sd101, 1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_TEST,    6'd5,  32'sd100, 1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_COMBINE, 6'd20, NEG_INF,  1'b0, NO_OUT},
        // overwrite of the best entry, then removal of the worst: both rescan
        '{1'b0, 1'b0, CMD_INSERT,  6'd0,  32'sd50,  1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_REMOVE,  6'd63, 32'sd0,   1'b0, NO_OUT},
        // tie on the best value keeps the earlier entry; removing that entry rescans to the other
        '{1'b0, 1'b0, CMD_INSERT,  6'd7,  -32'sd7,  1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_REMOVE,  6'd6,  32'sd0,   1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_TEST,    6'd42, -32'sd1,  1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_COMBINE, 6'd0,  32'sd0,   1'b0, NO_OUT},
        // switch to max is best: the table is cleared
        '{1'b1, 1'b0, CMD_TEST,    6'd0,  NEG_INF,  1'b1,
          '{NEG_INF, POS_INF, 6'd0, 1'b0, 1'b1, 32'sd0}},
        '{1'b0, 1'b0, CMD_INSERT,  6'd1,  NEG_INF,  1'b1,
          '{NEG_INF, NEG_INF, 6'd0, 1'b0, 1'b0, 32'sd0}},
        '{1'b0, 1'b0, CMD_INSERT,  6'd2,  POS_INF,  1'b1,
          '{POS_INF, NEG_INF, 6'd2, 1'b1, 1'b0, 32'sd0}},
        '{1'b0, 1'b0, CMD_INSERT,  6'd3,  -32'sd1,  1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_TEST,    6'd3,  -32'sd2,  1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_TEST,    6'd3,  32'sd0,   1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_COMBINE, 6'd9,  32'sd0,   1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_REMOVE,  6'd2,  32'sd0,   1'b0, NO_OUT},
        '{1'b0, 1'b0, CMD_INSERT,  6'd1,  32'sd7,   1'b0, NO_OUT}
    };

    logic clk = 1'b0;
    logic rst_n;

    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    logic   in_valid;
    logic   in_stall;
    cmd_t   command;
    slot_t  entry_index;
    bound_t bound_value;

    logic   out_valid;
    logic   out_stall;
    bound_t best_value;
    bound_t worst_value;
    slot_t  best_entry;
    logic   best_found;
    logic   is_better;
    bound_t combined_value;

    // pacing controls shared by the two sides
    logic pace_off;      // no random idling on either side
    logic long_hold_go;  // asks the result side for one long hold-off

    int err_cnt   = 0;
    int cyc_count = 0;

    // results still owed by the block, oldest first
    tracker_out_t awaited_results[$];

    // tracker model state
    logic   min_mode;
    logic   slot_used [ENTRIES];
    bound_t slot_bound [ENTRIES];
    bound_t best_val;
    bound_t worst_val;
    slot_t  best_idx;
    logic   best_ok;

    indexed_bound_best_worst_tracker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .entry_index    (entry_index),
        .bound_value    (bound_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .best_value     (best_value),
        .worst_value    (worst_value),
        .best_entry     (best_entry),
        .best_found     (best_found),
        .is_better      (is_better),
        .combined_value (combined_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cyc_count <= cyc_count + 1;
        if (cyc_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tracker model

    // strictly better / strictly worse under the current mode
    function automatic logic improves(input bound_t a, input bound_t b);
        return min_mode ? (a < b) : (a > b);
    endfunction

    function automatic logic degrades(input bound_t a, input bound_t b);
        return min_mode ? (a > b) : (a < b);
    endfunction

    // rebuild best and worst from the valid entries, first index wins a tie
    function automatic void rescan_table();
        best_ok   = 1'b0;
        best_idx  = '0;
        best_val  = min_mode ? POS_INF : NEG_INF;
        worst_val = min_mode ? NEG_INF : POS_INF;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (slot_used[k])
            begin
                if (improves(slot_bound[k], best_val))
                begin
                    best_val = slot_bound[k];
                    best_idx = slot_t'(k);
                    best_ok  = 1'b1;
                end
                if (degrades(slot_bound[k], worst_val))
                    worst_val = slot_bound[k];
            end
        end
    endfunction

    // mode write or reset: empty table, sentinels for the new mode
    function automatic void reinit_tracker(input logic mode);
        min_mode = mode;
        for (int k = 0; k < ENTRIES; k++)
        begin
            slot_used[k]  = 1'b0;
            slot_bound[k] = '0;
        end
        rescan_table();
    endfunction

    // apply one command to the model and return the result it owes
    function automatic tracker_out_t track_command(input cmd_t c, input slot_t i,
                                                   input bound_t v);
        tracker_out_t r;
        r = '0;
        case (c)
            CMD_INSERT:
            begin
                // overwriting an entry that holds the best or worst forces a rescan
                if (slot_used[i] && (slot_bound[i] == best_val || slot_bound[i] == worst_val))
                begin
                    slot_bound[i] = v;
                    rescan_table();
                end
                else
                begin
                    slot_used[i]  = 1'b1;
                    slot_bound[i] = v;
                    if (improves(v, best_val))
                    begin
                        best_val = v;
                        best_idx = i;
                        best_ok  = 1'b1;
                    end
                    if (degrades(v, worst_val))
                        worst_val = v;
                end
            end
            CMD_REMOVE:
            begin
                if (slot_used[i])
                begin
                    slot_used[i] = 1'b0;
                    if (slot_bound[i] == best_val || slot_bound[i] == worst_val)
                        rescan_table();
                end
            end
            CMD_TEST:
                // an absent entry is always improved on
                r.is_better = !(slot_used[i] &&
                                (min_mode ? (v <= slot_bound[i]) : (v >= slot_bound[i])));
            default:
                r.combined_value = improves(v, best_val) ? v : best_val;
        endcase
        r.best_value  = best_val;
        r.worst_value = worst_val;
        r.best_entry  = best_ok ? best_idx : '0;
        r.best_found  = best_ok;
        return r;
    endfunction

    // ---------------------------------------------------------------- pacing

    // idle run length: mostly short, some medium, a few long
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // result side: random stall runs, plus one long hold-off on request
    initial
    begin : result_pacing
        int unsigned hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_go)
            begin
                long_hold_go <= 1'b0;
                hold = LONG_HOLD;
            end
            else if (hold == 0 && !pace_off && $urandom_range(0, 3) == 0)
                hold = pick_idle();
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- result checking

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // sample at the falling edge, where the handshake and payload are settled;
    // a transfer here completes at the next rising edge
    initial
    begin : result_monitor
        tracker_out_t got;
        tracker_out_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got = '{best_value, worst_value, best_entry, best_found, is_better,
                        combined_value};
                if (awaited_results.size() == 0)
                begin
                    err_cnt++;
                    $error("result transfer with no pending command");
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("best_value", want.best_value, got.best_value);
                    check_field("worst_value", want.worst_value, got.worst_value);
                    check_field("best_entry", want.best_entry, got.best_entry);
                    check_field("best_found", want.best_found, got.best_found);
                    check_field("is_better", want.is_better, got.is_better);
                    check_field("combined_value", want.combined_value, got.combined_value);
                end
            end
        end
    end

    // ---------------------------------------------------------------- command side

    // offer one command; returns at the rising edge where the transfer happened
    task automatic offer_item(input cmd_t c, input slot_t i, input bound_t v,
                              input logic typed, input tracker_out_t typed_out);
        tracker_out_t pred;
        logic taken;
        if (!pace_off && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat (pick_idle()) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= c;
        entry_index <= i;
        bound_value <= v;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        pred = track_command(c, i, v);
        awaited_results.push_back(typed ? typed_out : pred);
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_results.size() != 0);
        @(posedge clk);
    endtask

    // apb write of the mode register, then read it back; block must be idle
    task automatic write_mode(input logic m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= APB_DATA_BITS'(m);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        @(posedge clk);
        reinit_tracker(m);
        // read-back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        if (prdata !== APB_DATA_BITS'(m))
        begin
            err_cnt++;
            $error("prdata: expected %0d, got %0d", m, prdata);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : stimulus
        cmd_t        c;
        slot_t       i;
        bound_t      v;
        slot_t       win_base;
        int unsigned r;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        command      = CMD_INSERT;
        entry_index  = '0;
        bound_value  = '0;
        pace_off     = 1'b0;
        long_hold_go = 1'b0;
        reinit_tracker(1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int n = 0; n < DIR_LEN; n++)
        begin
            if (DIR_ROWS[n].mode_wr)
            begin
                settle();
                write_mode(DIR_ROWS[n].mode_val);
            end
            offer_item(DIR_ROWS[n].cmd, DIR_ROWS[n].idx, DIR_ROWS[n].val,
                       DIR_ROWS[n].typed, DIR_ROWS[n].want);
        end

        // random phases, each starting from a freshly cleared table
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_mode(ph == 0 ? 1'b1 : ph == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
            // a narrow index window per phase keeps hitting live entries
            win_base = slot_t'($urandom);
            // phase 2 runs flat out on both sides
            pace_off <= (ph == 2);
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                // fill the block behind a long result hold-off
                if (ph == 3 && n == 40)
                    long_hold_go <= 1'b1;
                // sender pause until everything owed has come back
                if (ph == 1 && n == 100)
                    settle();

                r = $urandom_range(0, 99);
                c = (r < 45) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
                    (r < 85) ? CMD_TEST : CMD_COMBINE;

                if ($urandom_range(0, 9) < 6)
                    i = slot_t'(win_base + $urandom_range(0, 7));
                else
                    i = slot_t'($urandom);

                // sentinels and small values make ties and extreme hits common
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    case ($urandom_range(0, 4))
                        0:       v = POS_INF;
                        1:       v = NEG_INF;
                        2:       v = '0;
                        3:       v = -1;
                        default: v = 1;
                    endcase
                end
                else if (r < 50)
                    v = bound_t'(int'($urandom_range(0, 40)) - 20);
                else
                    v = bound_t'($urandom);

                offer_item(c, i, v, 1'b0, NO_OUT);
            end
        end

        // drain, then allow a full rescan worth of cycles for stray results
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
